/* src/pip_pkg.sv */
`default_nettype none
package pip_pkg;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;
	localparam int CFG_IDX_BITS     = 1;
	localparam int CFG_DATA_BITS    = 7;
	localparam int TALLY_BITS       = 8;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FILL_RULE    = 1'd1;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_WALK,
		ST_DRAIN
	} walk_state_t;
endpackage
`default_nettype wire

/* src/pip_if.sv */
`default_nettype none
interface pip_req_if #(parameter int COORD_BITS = 16, parameter int IDX_BITS = 6);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [IDX_BITS-1:0]   vertex_index;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	modport source (output valid, command, vertex_index, point_x, point_y, input ready);
	modport sink (input valid, command, vertex_index, point_x, point_y, output ready);
endinterface

interface pip_res_if;
	logic              valid;
	logic              ready;
	logic              inside_res;
	logic signed [7:0] crossing_tally;
	modport source (output valid, inside_res, crossing_tally, input ready);
	modport sink (input valid, inside_res, crossing_tally, output ready);
endinterface
`default_nettype wire

/* src/pip_ram.sv */
`default_nettype none
module pip_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/point_in_polygon_test.sv */
// Channel   Direction  Payload
// req       sink       command, vertex_index, point_x, point_y
// res       source     inside_res, crossing_tally
// cfg       write      cfg_we, cfg_index, cfg_data
//
// A load request is written into the vertex memory when it is taken. The walk
// of a test is paced by the read address that the x and y vertex memories
// share, which gives one vertex per cycle to an edge pipeline (memory data,
// offsets and direction, cross multiply, compare and classify, accumulate).
// With fewer than three vertices a test skips the walk, and its result,
// inside with a zero tally, is registered when the request is taken. Reset
// clears control state, configuration and tally; other data registers are not
// reset, and the vertex memory is undefined until loaded. A stalled result
// waits in the output register while no new request is taken.
`default_nettype none
module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	pip_req_if.sink                       req,
	pip_res_if.source                     res,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int TW = CW + 1;

	// Configuration. The count field is wider than needed for small
	// polygons, so it is saturated at MAX_VERTICES when read.
	logic [6:0] vcount_q;
	logic       fill_rule_q;
	logic [CW:0] n_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= '0;
			fill_rule_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vcount_q    <= cfg_data;
				REG_FILL_RULE:    fill_rule_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(vcount_q) > MAX_VERTICES) begin
			n_sat = (CW+1)'(MAX_VERTICES);
		end else begin
			n_sat = (CW+1)'(vcount_q);
		end
	end

	walk_state_t state_q, state_d;
	logic [AW-1:0] rd_idx_q;
	logic [CW:0]   issued_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic first_v_s1;
	logic issue_v;
	logic last_issue;
	logic req_fire;
	logic res_busy_q;
	logic small_poly;
	logic [AW-1:0] raddr;
	logic [COORD_BITS-1:0] rx, ry;

	assign small_poly = (n_sat < (CW+1)'(3));
	assign req_fire   = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE) && !res_busy_q;

	pip_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_x (
		.clk(clk),
		.we(req_fire && req.command == CMD_LOAD && 32'(req.vertex_index) < MAX_VERTICES),
		.waddr(AW'(req.vertex_index)), .wdata(req.point_x),
		.raddr(raddr), .rdata(rx)
	);
	pip_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_y (
		.clk(clk),
		.we(req_fire && req.command == CMD_LOAD && 32'(req.vertex_index) < MAX_VERTICES),
		.waddr(AW'(req.vertex_index)), .wdata(req.point_y),
		.raddr(raddr), .rdata(ry)
	);

	// The walk reads vertex 0 first and then vertices 1..n-1 and 0 again, so
	// each read after the first closes one edge with the previous vertex.
	assign issue_v    = (state_q == ST_FIRST) || (state_q == ST_WALK);
	assign last_issue = (state_q == ST_WALK) && (issued_q == n_sat);
	assign raddr      = (state_q == ST_WALK && issued_q == n_sat) ? '0 : rd_idx_q;

	logic drain_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (req_fire && req.command == CMD_TEST && !small_poly) begin
				state_d = ST_FIRST;
			end
			ST_FIRST: state_d = ST_WALK;
			ST_WALK:  if (last_issue) begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: if (drain_done) begin
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			issued_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				rd_idx_q <= '0;
				issued_q <= '0;
			end else if (issue_v) begin
				rd_idx_q <= (32'(rd_idx_q) + 1 >= MAX_VERTICES) ? '0 : rd_idx_q + 1'b1;
				issued_q <= issued_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			px_q <= req.point_x;
			py_q <= req.point_y;
		end
	end

	// Stage 1: memory data arrives; valid marks a read, and the first read of a walk, which closes no edge, is flagged.
	logic v_s1, last_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			first_v_s1 <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			v_s1       <= issue_v;
			first_v_s1 <= (state_q == ST_FIRST);
			last_s1    <= last_issue;
		end
	end

	// Stage 2: previous vertex held, offsets and direction tests.
	logic signed [COORD_BITS-1:0] ax_q, ay_q;
	logic v_s2, last_s2, up_s2, down_s2;
	logic signed [DW-1:0] ex_s2, ey_s2, dx_s2, dy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1 && !first_v_s1;
			last_s2 <= last_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (v_s1) begin
			ax_q <= rx;
			ay_q <= ry;
			ex_s2   <= DW'($signed(rx)) - DW'(ax_q);
			ey_s2   <= DW'($signed(ry)) - DW'(ay_q);
			dx_s2   <= DW'(px_q) - DW'(ax_q);
			dy_s2   <= DW'(py_q) - DW'(ay_q);
			up_s2   <= (ay_q <= py_q) && ($signed(ry) > py_q);
			down_s2 <= (ay_q > py_q) && ($signed(ry) <= py_q);
		end
	end

	// Stage 3: the two cross products.
	logic v_s3, last_s3, up_s3, down_s3;
	logic signed [PW-1:0] lhs_s3, rhs_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			v_s3    <= v_s2;
			last_s3 <= last_s2;
		end
	end
	always_ff @(posedge clk) begin
		lhs_s3  <= PW'(ex_s2) * PW'(dy_s2);
		rhs_s3  <= PW'(dx_s2) * PW'(ey_s2);
		up_s3   <= up_s2;
		down_s3 <= down_s2;
	end

	// Stage 4: compare and classify the edge.
	logic v_s4, last_s4, inc_s4, dec_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4    <= 1'b0;
			last_s4 <= 1'b0;
			inc_s4  <= 1'b0;
			dec_s4  <= 1'b0;
		end else begin
			v_s4    <= v_s3;
			last_s4 <= last_s3;
			inc_s4  <= v_s3 && up_s3 && (lhs_s3 > rhs_s3);
			dec_s4  <= v_s3 && down_s3 && (lhs_s3 < rhs_s3);
		end
	end

	// Accumulation; the tally never exceeds the vertex count in magnitude.
	logic signed [TW-1:0] tally_q, tally_next;
	always_comb begin
		tally_next = tally_q;
		if (inc_s4) begin
			tally_next = tally_q + 1'b1;
		end else if (dec_s4) begin
			tally_next = fill_rule_q ? tally_q + 1'b1 : tally_q - 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (state_q == ST_IDLE) begin
			tally_q <= '0;
		end else if (v_s4) begin
			tally_q <= tally_next;
		end
	end
	assign drain_done = v_s4 && last_s4;

	logic signed [TALLY_BITS-1:0] sat_tally;
	always_comb begin
		if (tally_next > TW'(127) && TW > TALLY_BITS) begin
			sat_tally = 8'sd127;
		end else if (tally_next < -TW'(128) && TW > TALLY_BITS) begin
			sat_tally = -8'sd128;
		end else begin
			sat_tally = TALLY_BITS'(tally_next);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_busy_q <= 1'b0;
		end else if (req_fire && req.command == CMD_TEST && small_poly) begin
			res_busy_q <= 1'b1;
		end else if (drain_done) begin
			res_busy_q <= 1'b1;
		end else if (res.ready) begin
			res_busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (req_fire && req.command == CMD_TEST && small_poly) begin
			res.inside_res     <= 1'b1;
			res.crossing_tally <= '0;
		end else if (drain_done) begin
			res.inside_res     <= fill_rule_q ? tally_next[0] : (tally_next != '0);
			res.crossing_tally <= sat_tally;
		end
	end
	assign res.valid = res_busy_q;
endmodule
`default_nettype wire

/* src/pip_checker.sv */
`default_nettype none
module pip_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic req_command,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic res_inside,
	input wire logic [7:0] res_tally
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_tally))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request taken while result waits");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command |=> !req_ready)
		else $error("request taken right after a test");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_inside |-> res_tally != 8'd1)
		else $error("outside with odd unit tally");
endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .req_command(req.command),
	.res_valid(res.valid), .res_ready(res.ready),
	.res_inside(res.inside_res), .res_tally(res.crossing_tally)
);
`default_nettype wire

/* sim/tb_point_in_polygon_test.sv */
`default_nettype none
module tb_point_in_polygon_test;
	import pip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS    = MAX_VERTICES_DEF;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 800000;

	typedef struct {
		logic                     command;
		logic [5:0]               vertex_index;
		logic signed [15:0]       point_x;
		logic signed [15:0]       point_y;
	} poly_req_t;

	typedef struct {
		logic                     inside_res;
		logic signed [7:0]        crossing_tally;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	pip_req_if #(.COORD_BITS(16), .IDX_BITS(6)) req_ch ();
	pip_res_if res_ch ();

	point_in_polygon_test i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// The testbench's own copy of the polygon and of the two registers.
	logic signed [15:0] shadow_x [NUM_SLOTS];
	logic signed [15:0] shadow_y [NUM_SLOTS];
	logic [6:0]         shadow_count = '0;
	logic               shadow_rule = 1'b0;

	poly_req_t pending_reqs [$];
	verdict_t  awaited_verdicts [$];

	int  failures = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	bit  req_taken = 1'b0;
	bit  res_taken = 1'b0;
	int  send_gap = 0;
	int  stall_left = 0;

	// Works out the verdict for one tested point. Each edge is judged by the exact
	// sign of its cross product with the point offset. An upward edge counts when
	// the point lies strictly to its left, a downward edge when strictly to its right.
	function automatic verdict_t classify_point(logic signed [15:0] px, logic signed [15:0] py);
		verdict_t v;
		int       n;
		int       j;
		longint   ax, ay, bx, by, lhs, rhs, tally;
		tally = 0;
		n = (shadow_count > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_count);
		if (n < 3) begin
			v.inside_res = 1'b1;
			v.crossing_tally = '0;
			return v;
		end
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			ax = shadow_x[i];
			ay = shadow_y[i];
			bx = shadow_x[j];
			by = shadow_y[j];
			lhs = (bx - ax) * (longint'(py) - ay);
			rhs = (longint'(px) - ax) * (by - ay);
			if (ay <= py) begin
				if (by > py && lhs > rhs)
					tally += 1;
			end else if (by <= py && lhs < rhs) begin
				tally += shadow_rule ? 1 : -1;
			end
		end
		v.inside_res = shadow_rule ? tally[0] : (tally != 0);
		if (tally > 127)
			tally = 127;
		if (tally < -128)
			tally = -128;
		v.crossing_tally = tally[7:0];
		return v;
	endfunction

	function automatic logic signed [15:0] coord_in(int radius);
		return 16'(int'($urandom_range(0, 2 * radius)) - radius);
	endfunction

	task automatic push_req(logic cmd, logic [5:0] idx, logic signed [15:0] x,
			logic signed [15:0] y);
		poly_req_t r;
		r.command = cmd;
		r.vertex_index = idx;
		r.point_x = x;
		r.point_y = y;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// Register writes happen only while the block is idle, so the shadow copy can
	// be updated at once.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [6:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_VERTEX_COUNT)
			shadow_count = value;
		else
			shadow_rule = value[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued request has gone in and every verdict has come out.
	// A load leaves no verdict behind it, but it is taken only once any earlier test
	// is done, so no walk is still running; the extra cycles are only a margin.
	task automatic wait_quiet();
		while (pending_reqs.size() != 0 || req_ch.valid || awaited_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random phase: a fresh setting, mostly a polygon of random vertices followed by
	// points in the same square range, with some stray loads and far-off points mixed in.
	task automatic random_phase();
		int sel;
		int radius;
		int n;
		sel = $urandom_range(0, 19);
		case (sel)
			0: n = $urandom_range(0, 2);
			1: n = 64;
			2: n = $urandom_range(65, 127);
			3, 4: n = $urandom_range(13, 63);
			default: n = $urandom_range(3, 12);
		endcase
		case ($urandom_range(0, 2))
			0: radius = 8;
			1: radius = 300;
			default: radius = 32767;
		endcase
		idle_on = ($urandom_range(0, 3) != 0);
		write_reg(REG_VERTEX_COUNT, 7'(n));
		write_reg(REG_FILL_RULE, 7'($urandom_range(0, 1)));
		for (int s = 0; s < n && s < NUM_SLOTS; s++)
			push_req(CMD_LOAD, 6'(s), coord_in(radius), coord_in(radius));
		for (int k = 0; k < 90; k++) begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				push_req(CMD_LOAD, 6'($urandom), 16'($urandom), 16'($urandom));
			else if (sel < 3)
				push_req(CMD_TEST, 6'($urandom), 16'($urandom), 16'($urandom));
			else
				push_req(CMD_TEST, 6'($urandom), coord_in(radius), coord_in(radius));
		end
		wait_quiet();
	endtask

	// Driver: requests change on the falling edge. A request stays up until it is
	// taken, then the line rests for the drawn number of cycles.
	always @(negedge clk) begin
		logic      next_valid;
		poly_req_t r;
		next_valid = req_ch.valid;
		if (req_taken) begin
			next_valid = 1'b0;
			req_taken = 1'b0;
		end
		if (!next_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_reqs.size() != 0) begin
				r = pending_reqs.pop_front();
				req_ch.command <= r.command;
				req_ch.vertex_index <= r.vertex_index;
				req_ch.point_x <= r.point_x;
				req_ch.point_y <= r.point_y;
				next_valid = 1'b1;
				send_gap = idle_on ? $urandom_range(0, 5) : 0;
			end
		end
		req_ch.valid <= next_valid;
	end

	// The result side holds ready low for a drawn number of cycles after each verdict that it takes.
	always @(negedge clk) begin
		if (res_taken) begin
			res_taken = 1'b0;
			stall_left = idle_on ? $urandom_range(0, 5) : 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Monitor: on the rising edge, an accepted load updates the shadow polygon and
	// an accepted test queues its verdict; an accepted verdict is checked against
	// the oldest one waiting.
	always @(posedge clk) begin
		verdict_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			req_taken = 1'b1;
			if (req_ch.command == CMD_LOAD) begin
				shadow_x[req_ch.vertex_index] = req_ch.point_x;
				shadow_y[req_ch.vertex_index] = req_ch.point_y;
			end else begin
				awaited_verdicts.insert(awaited_verdicts.size(),
					classify_point(req_ch.point_x, req_ch.point_y));
			end
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			res_taken = 1'b1;
			if (awaited_verdicts.size() == 0) begin
				$error("verdict arrived with none awaited");
				failures++;
			end else begin
				want = awaited_verdicts.pop_front();
				if (res_ch.inside_res !== want.inside_res) begin
					$error("inside_res: expected %0d, got %0d", want.inside_res,
						res_ch.inside_res);
					failures++;
				end
				if (res_ch.crossing_tally !== want.crossing_tally) begin
					$error("crossing_tally: expected %0d, got %0d", want.crossing_tally,
						res_ch.crossing_tally);
					failures++;
				end
			end
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.vertex_index = '0;
		req_ch.point_x = '0;
		req_ch.point_y = '0;
		res_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With no vertices in use, every point is inside with a zero tally.
		push_req(CMD_TEST, 6'd63, -16'sd32768, -16'sd32768);
		push_req(CMD_TEST, 6'd0, 16'sd32767, 16'sd32767);
		// The largest square the coordinates allow, in the four corner slots.
		push_req(CMD_LOAD, 6'd0, -16'sd32768, -16'sd32768);
		push_req(CMD_LOAD, 6'd1, 16'sd32767, -16'sd32768);
		push_req(CMD_LOAD, 6'd2, 16'sd32767, 16'sd32767);
		push_req(CMD_LOAD, 6'd3, -16'sd32768, 16'sd32767);
		wait_quiet();

		write_reg(REG_VERTEX_COUNT, 7'd4);
		for (int rule = 0; rule < 2; rule++) begin
			write_reg(REG_FILL_RULE, 7'(rule));
			// Centre, a corner, points on the bottom and left edges, and the top and right edges.
			push_req(CMD_TEST, 6'd0, 16'sd0, 16'sd0);
			push_req(CMD_TEST, 6'd0, -16'sd32768, -16'sd32768);
			push_req(CMD_TEST, 6'd0, 16'sd5, -16'sd32768);
			push_req(CMD_TEST, 6'd0, -16'sd32768, 16'sd7);
			push_req(CMD_TEST, 6'd0, 16'sd100, 16'sd32767);
			push_req(CMD_TEST, 6'd0, 16'sd32767, 16'sd0);
			wait_quiet();
		end

		// Two vertices in use: the walk is skipped and the point counts as inside.
		write_reg(REG_VERTEX_COUNT, 7'd2);
		push_req(CMD_TEST, 6'd0, 16'sd32767, -16'sd32768);
		wait_quiet();

		// Fill the whole table so that no later setting reads an unwritten slot.
		for (int s = 0; s < NUM_SLOTS; s++)
			push_req(CMD_LOAD, 6'(s), 16'($urandom), 16'($urandom));
		wait_quiet();

		// A count above the table size saturates to the full table.
		write_reg(REG_VERTEX_COUNT, 7'd127);
		write_reg(REG_FILL_RULE, 7'd1);
		push_req(CMD_TEST, 6'd0, 16'sd0, 16'sd0);
		push_req(CMD_TEST, 6'd0, 16'($urandom), 16'($urandom));
		wait_quiet();

		repeat (11) random_phase();

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
src/pip_pkg.sv
src/pip_if.sv
src/pip_ram.sv
src/point_in_polygon_test.sv
src/pip_checker.sv
sim/tb_point_in_polygon_test.sv
